[rtl/daq_event_word_unpacker_defines.svh]
// Assertion macros shared by the readout word unpacker.
`ifndef DAQ_EVENT_WORD_UNPACKER_DEFINES_SVH
`define DAQ_EVENT_WORD_UNPACKER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define DEWU_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("dewu: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define DEWU_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("dewu: next-cycle check failed");

`endif

[rtl/dewu_pkg.sv]
// Types and constants of the readout word unpacker.
`default_nettype none
package dewu_pkg;

  // Result kinds.
  localparam logic [3:0] KIND_HEADER  = 4'd0;
  localparam logic [3:0] KIND_ADC     = 4'd1;
  localparam logic [3:0] KIND_TDC     = 4'd2;
  localparam logic [3:0] KIND_TRIGGER = 4'd3;
  localparam logic [3:0] KIND_EXT_TS  = 4'd4;
  localparam logic [3:0] KIND_EVT_TS  = 4'd5;
  localparam logic [3:0] KIND_IGNORED = 4'd6;
  localparam logic [3:0] KIND_SKIPPED = 4'd7;
  localparam logic [3:0] KIND_CLEARED = 4'd8;

  // Data word type codes in the top nibble or top two bits.
  localparam logic [3:0] NIB_HIT     = 4'h1;
  localparam logic [3:0] NIB_EXT_TS  = 4'h2;
  localparam logic [1:0] TOP_EVT_TS  = 2'b11;

  // Channel ranges, by upper channel bits.
  localparam logic [1:0] CH_GRP_ADC  = 2'b00;
  localparam logic [1:0] CH_GRP_TDC  = 2'b01;
  localparam logic [5:0] CH_GRP_TRIG = 6'b100000;

  localparam logic       OP_STREAM   = 1'b0;
  localparam logic       OP_CLEAR    = 1'b1;

  localparam int unsigned LEN_W      = 13;

  // Queue between the classifier and the list logic.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // A classified item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  chan;
    logic [15:0] value;
    logic [29:0] stamp;
    logic [15:0] broken;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

[rtl/dewu_if.sv]
// Handshake channels of the readout word unpacker.
`default_nettype none
interface dewu_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] word;

  modport source (output valid, output opcode, output word, input ready);
  modport sink   (input valid, input opcode, input word, output ready);
endinterface

interface dewu_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [6:0]  slot;
  logic [4:0]  hit_channel;
  logic [15:0] hit_value;
  logic [6:0]  adc_count;
  logic [6:0]  tdc_count;
  logic [4:0]  trigger_count;
  logic [15:0] extended_stamp;
  logic [29:0] event_stamp;
  logic [15:0] broken_frames;

  modport source (output valid, output kind, output slot, output hit_channel,
                  output hit_value, output adc_count, output tdc_count,
                  output trigger_count, output extended_stamp, output event_stamp,
                  output broken_frames, input ready);
  modport sink   (input valid, input kind, input slot, input hit_channel,
                  input hit_value, input adc_count, input tdc_count,
                  input trigger_count, input extended_stamp, input event_stamp,
                  input broken_frames, output ready);
endinterface
`default_nettype wire

[rtl/dewu_front.sv]
// Front end: frame tracking and classification of stream words.
`default_nettype none
module dewu_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                accept_i,
  input  wire                opcode_i,
  input  wire  [31:0]        word_i,
  output dewu_pkg::item_t    item_o
);

  logic [dewu_pkg::LEN_W-1:0] words_left_q, words_left_d;
  logic                       skip_q, skip_d;
  logic [15:0]                broken_q, broken_d;
  logic [dewu_pkg::LEN_W-1:0] len;
  logic [6:0]                 ch;

  assign len = word_i[dewu_pkg::LEN_W-1:0];
  assign ch  = word_i[22:16];

  always_comb begin
    words_left_d = words_left_q;
    skip_d       = skip_q;
    broken_d     = broken_q;
    item_o.kind  = dewu_pkg::KIND_IGNORED;
    item_o.chan  = 5'd0;
    item_o.value = 16'd0;
    item_o.stamp = 30'd0;
    if (opcode_i == dewu_pkg::OP_CLEAR) begin
      item_o.kind = dewu_pkg::KIND_CLEARED;
    end else if (skip_q) begin
      skip_d      = 1'b0;
      item_o.kind = dewu_pkg::KIND_SKIPPED;
    end else if (words_left_q == '0) begin
      item_o.kind  = dewu_pkg::KIND_HEADER;
      item_o.value = 16'(len);
      if (len > dewu_pkg::LEN_W'(1)) begin
        words_left_d = len;
      end else if (len == dewu_pkg::LEN_W'(1)) begin
        skip_d = 1'b1;
        if (broken_q != 16'hFFFF) begin
          broken_d = broken_q + 16'd1;
        end
      end
    end else begin
      words_left_d = words_left_q - dewu_pkg::LEN_W'(1);
      if (word_i[31:28] == dewu_pkg::NIB_HIT) begin
        if (ch[6:5] == dewu_pkg::CH_GRP_ADC) begin
          item_o.kind  = dewu_pkg::KIND_ADC;
          item_o.chan  = ch[4:0];
          item_o.value = word_i[15:0];
        end else if (ch[6:5] == dewu_pkg::CH_GRP_TDC) begin
          item_o.kind  = dewu_pkg::KIND_TDC;
          item_o.chan  = ch[4:0];
          item_o.value = word_i[15:0];
        end else if (ch[6:1] == dewu_pkg::CH_GRP_TRIG) begin
          item_o.kind  = dewu_pkg::KIND_TRIGGER;
          item_o.chan  = {4'd0, ch[0]};
          item_o.value = word_i[15:0];
        end
      end else if (word_i[31:28] == dewu_pkg::NIB_EXT_TS) begin
        item_o.kind  = dewu_pkg::KIND_EXT_TS;
        item_o.stamp = {14'd0, word_i[15:0]};
      end else if (word_i[31:30] == dewu_pkg::TOP_EVT_TS) begin
        item_o.kind  = dewu_pkg::KIND_EVT_TS;
        item_o.stamp = word_i[29:0];
      end
    end
    item_o.broken = broken_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= '0;
      skip_q       <= 1'b0;
      broken_q     <= 16'd0;
    end else if (accept_i) begin
      words_left_q <= words_left_d;
      skip_q       <= skip_d;
      broken_q     <= broken_d;
    end
  end

endmodule
`default_nettype wire

[rtl/dewu_queue.sv]
// Two-entry queue of classified items between front and back end.
`default_nettype none
module dewu_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire dewu_pkg::item_t   item_i,
  input  wire                    pop_i,
  output dewu_pkg::item_t        item_o,
  output dewu_pkg::queue_stat_t  stat_o
);

  dewu_pkg::item_t                  mem_q [dewu_pkg::QUEUE_DEPTH];
  logic [dewu_pkg::QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [dewu_pkg::QUEUE_CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == dewu_pkg::QUEUE_CNT_W'(dewu_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/dewu_back.sv]
// Back end: list counters, timestamps and the output register.
`default_nettype none
module dewu_back #(
  parameter int unsigned HIT_LIST_DEPTH  = 96,
  parameter int unsigned TRIG_LIST_DEPTH = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                have_i,
  input  wire dewu_pkg::item_t item_i,
  output logic               pop_o,
  dewu_out_if.source         out_o
);

  localparam int unsigned HitW  = $clog2(HIT_LIST_DEPTH);
  localparam int unsigned TrigW = $clog2(TRIG_LIST_DEPTH);
  localparam logic [HitW-1:0]  HitLast  = HitW'(HIT_LIST_DEPTH - 1);
  localparam logic [TrigW-1:0] TrigLast = TrigW'(TRIG_LIST_DEPTH - 1);

  logic [HitW-1:0]  adc_q, adc_d, tdc_q, tdc_d;
  logic [TrigW-1:0] trig_q, trig_d;
  logic [15:0]      ext_q, ext_d;
  logic [29:0]      evt_q, evt_d;
  logic [6:0]       slot_d;

  logic             valid_q;
  logic [3:0]       kind_q;
  logic [6:0]       slot_q;
  logic [4:0]       chan_q;
  logic [15:0]      value_q;
  logic [15:0]      broken_q;

  // A new item moves into the output register when that register is free
  // or is being emptied in this cycle.
  assign pop_o = have_i && (!valid_q || out_o.ready);

  always_comb begin
    adc_d  = adc_q;
    tdc_d  = tdc_q;
    trig_d = trig_q;
    ext_d  = ext_q;
    evt_d  = evt_q;
    slot_d = 7'd0;
    case (item_i.kind)
      dewu_pkg::KIND_CLEARED: begin
        adc_d  = '0;
        tdc_d  = '0;
        trig_d = '0;
        ext_d  = 16'd0;
        evt_d  = 30'd0;
      end
      dewu_pkg::KIND_ADC: begin
        slot_d = 7'(adc_q);
        if (adc_q != HitLast) begin
          adc_d = adc_q + 1'b1;
        end
      end
      dewu_pkg::KIND_TDC: begin
        slot_d = 7'(tdc_q);
        if (tdc_q != HitLast) begin
          tdc_d = tdc_q + 1'b1;
        end
      end
      dewu_pkg::KIND_TRIGGER: begin
        slot_d = 7'(trig_q);
        if (trig_q != TrigLast) begin
          trig_d = trig_q + 1'b1;
        end
      end
      dewu_pkg::KIND_EXT_TS: begin
        ext_d = item_i.stamp[15:0];
      end
      dewu_pkg::KIND_EVT_TS: begin
        evt_d = item_i.stamp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_q   <= '0;
      tdc_q   <= '0;
      trig_q  <= '0;
      ext_q   <= 16'd0;
      evt_q   <= 30'd0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        adc_q   <= adc_d;
        tdc_q   <= tdc_d;
        trig_q  <= trig_d;
        ext_q   <= ext_d;
        evt_q   <= evt_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= item_i.kind;
      slot_q   <= slot_d;
      chan_q   <= item_i.chan;
      value_q  <= item_i.value;
      broken_q <= item_i.broken;
    end
  end

  // Counts and stamps are shown as they stand after the item in the register.
  assign out_o.valid          = valid_q;
  assign out_o.kind           = kind_q;
  assign out_o.slot           = slot_q;
  assign out_o.hit_channel    = chan_q;
  assign out_o.hit_value      = value_q;
  assign out_o.adc_count      = 7'(adc_q);
  assign out_o.tdc_count      = 7'(tdc_q);
  assign out_o.trigger_count  = 5'(trig_q);
  assign out_o.extended_stamp = ext_q;
  assign out_o.event_stamp    = evt_q;
  assign out_o.broken_frames  = broken_q;

endmodule
`default_nettype wire

[rtl/daq_event_word_unpacker.sv]
// An accepted item is written into the queue and then moved into the output register.
// Throughput: one item per cycle while not stalled; the front end tracks framing at the input
// handshake, a two-entry queue decouples it from the list counters and the output register.
// The input stalls only when the queue is full, which happens when the output is held back.
// Reset clears frame state, broken-frame counter, list counts, timestamps, queue and valid.
// The input is ready for the first item as soon as reset is released.
`default_nettype none
`include "daq_event_word_unpacker_defines.svh"
module daq_event_word_unpacker #(
  parameter int unsigned HIT_LIST_DEPTH  = 96,
  parameter int unsigned TRIG_LIST_DEPTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dewu_in_if.sink     in_i,
  dewu_out_if.source  out_o
);

  dewu_pkg::item_t        front_item;
  dewu_pkg::item_t        queue_item;
  dewu_pkg::queue_stat_t  queue_stat;
  logic                   accept;
  logic                   pop;

  assign in_i.ready = !queue_stat.full;
  assign accept     = in_i.valid && !queue_stat.full;

  dewu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (in_i.opcode),
    .word_i   (in_i.word),
    .item_o   (front_item)
  );

  dewu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (queue_stat)
  );

  dewu_back #(
    .HIT_LIST_DEPTH  (HIT_LIST_DEPTH),
    .TRIG_LIST_DEPTH (TRIG_LIST_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .have_i (!queue_stat.empty),
    .item_i (queue_item),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // An accepted item is either still queued or already in the output register.
  `DEWU_ASSERT_NEXT(a_item_kept, clk_i, rst_ni, accept, (!queue_stat.empty || out_o.valid))
  // The queue never reports full and empty at once.
  `DEWU_ASSERT_NOW(a_queue_stat, clk_i, rst_ni, 1'b1, !(queue_stat.full && queue_stat.empty))
  // Only list hits carry a slot or a channel.
  `DEWU_ASSERT_NOW(a_no_slot, clk_i, rst_ni,
    (out_o.valid && out_o.kind != dewu_pkg::KIND_ADC
     && out_o.kind != dewu_pkg::KIND_TDC && out_o.kind != dewu_pkg::KIND_TRIGGER),
    (out_o.slot == 7'd0 && out_o.hit_channel == 5'd0))
  // A clear leaves all list counts at zero.
  `DEWU_ASSERT_NOW(a_clear_counts, clk_i, rst_ni,
    (out_o.valid && out_o.kind == dewu_pkg::KIND_CLEARED),
    (out_o.adc_count == 7'd0 && out_o.tdc_count == 7'd0 && out_o.trigger_count == 5'd0))

endmodule
`default_nettype wire
